### rtl/core/pwce_pkg.sv
package pwce_pkg;

  localparam int DATA_BITS = 4;
  localparam int SEG_TOTAL = 2 * DATA_BITS + 5;
  localparam int SEG_W     = $clog2(SEG_TOTAL + 1);
  localparam int BIT_W     = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
  localparam int TICK_W    = 16;
  localparam int REG_W     = 2;

  localparam logic [SEG_W-1:0] SEG_LAST   = SEG_W'(SEG_TOTAL);
  localparam logic [SEG_W-1:0] SEG_SYNC   = SEG_W'(1);
  localparam logic [SEG_W-1:0] SEG_DATA0  = SEG_W'(2);
  localparam logic [SEG_W-1:0] SEG_PARITY = SEG_W'(2 + 2 * DATA_BITS);

  localparam logic [TICK_W-1:0] START_LOW_RST = 16'd32000;
  localparam logic [TICK_W-1:0] SYNC_HIGH_RST = 16'd2000;
  localparam logic [TICK_W-1:0] SHORT_RST     = 16'd1000;
  localparam logic [TICK_W-1:0] LONG_RST      = 16'd3000;

  typedef enum logic [REG_W-1:0] {
    REG_START_LOW = 2'd0,
    REG_SYNC_HIGH = 2'd1,
    REG_SHORT     = 2'd2,
    REG_LONG      = 2'd3
  } reg_index_t;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

endpackage

### rtl/core/pwce_if.sv
interface pwce_cmd_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [pwce_pkg::DATA_BITS-1:0] command_code;

  modport source (output valid, output kind, output command_code, input ready);
  modport sink (input valid, input kind, input command_code, output ready);
endinterface

interface pwce_res_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic frame_done;

  modport source (output valid, output line_level, output busy_res, output frame_done,
                  input ready);
  modport sink (input valid, input line_level, input busy_res, input frame_done,
                output ready);
endinterface

### rtl/core/pulse_width_command_encoder.sv
// An accepted word's result word is registered and is valid in the cycle after acceptance.
// Throughput: one word per cycle; the result register is refilled in the same
// cycle it is taken, so input stalls only while a result waits unread.
// The segment length is picked from the next segment index in the accept cycle.
// Reset (rst, synchronous): line idle high, no frame, timing registers at defaults.
module pulse_width_command_encoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [pwce_pkg::REG_W-1:0]    wr_index,
  input  logic [pwce_pkg::TICK_W-1:0]   wr_data,
  pwce_cmd_if.sink                      cmd,
  pwce_res_if.source                    res
);

  logic [pwce_pkg::TICK_W-1:0]    start_low_ticks;
  logic [pwce_pkg::TICK_W-1:0]    sync_high_ticks;
  logic [pwce_pkg::TICK_W-1:0]    short_ticks;
  logic [pwce_pkg::TICK_W-1:0]    long_ticks;

  logic [pwce_pkg::DATA_BITS-1:0] latched_code, latched_code_next;
  logic [pwce_pkg::SEG_W-1:0]     segment_index, segment_index_next;
  logic [pwce_pkg::TICK_W-1:0]    ticks_left, ticks_left_next;
  logic                           line_out, line_out_next;
  logic                           sending, sending_next;
  logic                           done_next;

  logic                           accept;
  logic [pwce_pkg::SEG_W-1:0]     seg_inc;
  logic [pwce_pkg::SEG_W-1:0]     seg_off;
  logic [pwce_pkg::BIT_W-1:0]     bit_k;
  logic [pwce_pkg::DATA_BITS-1:0] code_rev;
  logic [pwce_pkg::TICK_W-1:0]    seg_len;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = !res.valid || res.ready;

  // Timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_low_ticks <= pwce_pkg::START_LOW_RST;
      sync_high_ticks <= pwce_pkg::SYNC_HIGH_RST;
      short_ticks     <= pwce_pkg::SHORT_RST;
      long_ticks      <= pwce_pkg::LONG_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        pwce_pkg::REG_START_LOW: start_low_ticks <= wr_data;
        pwce_pkg::REG_SYNC_HIGH: sync_high_ticks <= wr_data;
        pwce_pkg::REG_SHORT:     short_ticks     <= wr_data;
        pwce_pkg::REG_LONG:      long_ticks      <= wr_data;
        default: ;
      endcase
    end
  end

  // Data bits go MSB first: data slot k carries code bit DATA_BITS-1-k
  always_comb begin
    for (int i = 0; i < pwce_pkg::DATA_BITS; i++) begin
      code_rev[i] = latched_code[pwce_pkg::DATA_BITS-1-i];
    end
  end

  assign seg_inc = segment_index + pwce_pkg::SEG_W'(1);
  assign seg_off = (seg_inc - pwce_pkg::SEG_DATA0) >> 1;
  assign bit_k   = seg_off[pwce_pkg::BIT_W-1:0];

  always_comb begin
    if (seg_inc == pwce_pkg::SEG_SYNC) begin
      seg_len = sync_high_ticks;
    end else if (seg_inc[0]) begin
      seg_len = short_ticks;
    end else if (seg_inc < pwce_pkg::SEG_PARITY) begin
      seg_len = code_rev[bit_k] ? long_ticks : short_ticks;
    end else if (seg_inc == pwce_pkg::SEG_PARITY) begin
      seg_len = (^latched_code) ? long_ticks : short_ticks;
    end else begin
      seg_len = short_ticks;
    end
  end

  always_comb begin
    latched_code_next  = latched_code;
    segment_index_next = segment_index;
    ticks_left_next    = ticks_left;
    line_out_next      = line_out;
    sending_next       = sending;
    done_next          = 1'b0;
    if (cmd.kind == pwce_pkg::KIND_START) begin
      // restart: drop any frame in progress
      latched_code_next  = cmd.command_code;
      segment_index_next = '0;
      ticks_left_next    = start_low_ticks;
      line_out_next      = 1'b0;
      sending_next       = 1'b1;
    end else if (sending) begin
      if (ticks_left <= pwce_pkg::TICK_W'(1)) begin
        if (seg_inc == pwce_pkg::SEG_LAST) begin
          segment_index_next = '0;
          ticks_left_next    = '0;
          line_out_next      = 1'b1;
          sending_next       = 1'b0;
          done_next          = 1'b1;
        end else begin
          segment_index_next = seg_inc;
          ticks_left_next    = seg_len;
          line_out_next      = !line_out;
        end
      end else begin
        ticks_left_next = ticks_left - pwce_pkg::TICK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_code  <= '0;
      segment_index <= '0;
      ticks_left    <= '0;
      line_out      <= 1'b1;
      sending       <= 1'b0;
    end else if (accept) begin
      latched_code  <= latched_code_next;
      segment_index <= segment_index_next;
      ticks_left    <= ticks_left_next;
      line_out      <= line_out_next;
      sending       <= sending_next;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (accept) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.line_level <= line_out_next;
      res.busy_res   <= sending_next;
      res.frame_done <= done_next;
    end
  end

  a_idle_line_high: assert property (@(posedge clk) disable iff (rst)
    !sending |-> line_out)
    else $error("line low while no frame is in progress");

  a_seg_in_range: assert property (@(posedge clk) disable iff (rst)
    segment_index < pwce_pkg::SEG_LAST)
    else $error("segment index past end of frame");

  a_start_drives_low: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.kind == pwce_pkg::KIND_START |=> sending && !line_out
      && segment_index == '0)
    else $error("start word did not begin the opening low");

  a_done_ends_frame: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.frame_done |-> res.line_level && !res.busy_res && !sending)
    else $error("frame end reported while frame still active");

endmodule

### sim/tb_pulse_width_command_encoder.sv
module tb_pulse_width_command_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 200;
  localparam int PHASES        = 12;
  localparam int PHASE_WORDS   = 57;
  localparam int SQUEEZE_PHASE = 4;
  localparam int SETTLE_CYCLES = 8;

  // timing sets used by the directed script
  localparam int TIMING_RESET = 0;
  localparam int TIMING_ZERO  = 1;
  localparam int TIMING_MAX   = 2;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
  } line_word_t;

  localparam line_word_t WORD_IDLE  = '{line_level: 1'b1, busy_res: 1'b0, frame_done: 1'b0};
  localparam line_word_t WORD_START = '{line_level: 1'b0, busy_res: 1'b1, frame_done: 1'b0};
  localparam line_word_t WORD_DONE  = '{line_level: 1'b1, busy_res: 1'b0, frame_done: 1'b1};

  typedef struct {
    int                             timing;
    logic                           kind;
    logic [pwce_pkg::DATA_BITS-1:0] code;
    bit                             typed;
    line_word_t                     want;
  } script_row_t;

  logic                        clk;
  logic                        rst;
  logic                        wr_en;
  logic [pwce_pkg::REG_W-1:0]  wr_index;
  logic [pwce_pkg::TICK_W-1:0] wr_data;

  pwce_cmd_if cmd_if ();
  pwce_res_if res_if ();

  pulse_width_command_encoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cmd      (cmd_if),
    .res      (res_if)
  );

  // encoder state as the testbench sees it
  logic [pwce_pkg::TICK_W-1:0]    t_start, t_sync, t_short, t_long;
  logic [pwce_pkg::DATA_BITS-1:0] cur_code;
  logic [pwce_pkg::SEG_W-1:0]     cur_seg;
  logic [pwce_pkg::TICK_W-1:0]    ticks_rem;
  logic                           line_q;
  logic                           sending_q;

  line_word_t  line_words[$];
  script_row_t script[$];

  int errors      = 0;
  int words_sent  = 0;
  int words_seen  = 0;
  int frames_done = 0;
  int starts      = 0;
  int restarts    = 0;
  int settings    = 1;
  int holds       = 0;
  bit squeeze_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [pwce_pkg::TICK_W-1:0] seg_ticks(
      input logic [pwce_pkg::SEG_W-1:0] s);
    int bp;
    if (s == '0) return t_start;
    if (s == pwce_pkg::SEG_SYNC) return t_sync;
    if (s[0]) return t_short;
    if (s < pwce_pkg::SEG_PARITY) begin
      bp = pwce_pkg::DATA_BITS - 1 - (int'(s) - int'(pwce_pkg::SEG_DATA0)) / 2;
      return cur_code[bp] ? t_long : t_short;
    end
    if (s == pwce_pkg::SEG_PARITY) return (^cur_code) ? t_long : t_short;
    return t_short;
  endfunction

  function automatic line_word_t advance_line(input logic k,
                                              input logic [pwce_pkg::DATA_BITS-1:0] c);
    line_word_t w;
    w.frame_done = 1'b0;
    if (k == pwce_pkg::KIND_START) begin
      cur_code  = c;
      cur_seg   = '0;
      ticks_rem = seg_ticks('0);
      line_q    = 1'b0;
      sending_q = 1'b1;
    end else if (sending_q) begin
      // a count of zero or one expires on this tick
      if (ticks_rem <= pwce_pkg::TICK_W'(1)) begin
        ticks_rem = '0;
        cur_seg   = cur_seg + pwce_pkg::SEG_W'(1);
        line_q    = ~line_q;
        if (cur_seg >= pwce_pkg::SEG_LAST) begin
          cur_seg      = '0;
          sending_q    = 1'b0;
          line_q       = 1'b1;
          w.frame_done = 1'b1;
        end else begin
          ticks_rem = seg_ticks(cur_seg);
        end
      end else begin
        ticks_rem = ticks_rem - pwce_pkg::TICK_W'(1);
      end
    end
    w.line_level = line_q;
    w.busy_res   = sending_q;
    return w;
  endfunction

  function automatic void add_row(input int t, input logic k,
                                  input logic [pwce_pkg::DATA_BITS-1:0] c,
                                  input bit typed, input line_word_t w);
    script_row_t row;
    row.timing = t;
    row.kind   = k;
    row.code   = c;
    row.typed  = typed;
    row.want   = w;
    script.push_back(row);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [pwce_pkg::TICK_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return pwce_pkg::TICK_W'($urandom_range(0, 4));
    if (r < 85) return pwce_pkg::TICK_W'($urandom_range(5, 40));
    if (r < 93) return '1;
    return pwce_pkg::TICK_W'($urandom_range(0, 65535));
  endfunction

  task automatic write_reg(input pwce_pkg::reg_index_t idx,
                           input logic [pwce_pkg::TICK_W-1:0] v);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= v;
    @(posedge clk);
    case (idx)
      pwce_pkg::REG_START_LOW: t_start = v;
      pwce_pkg::REG_SYNC_HIGH: t_sync  = v;
      pwce_pkg::REG_SHORT:     t_short = v;
      pwce_pkg::REG_LONG:      t_long  = v;
    endcase
  endtask

  task automatic program_timing(input logic [pwce_pkg::TICK_W-1:0] s,
                                input logic [pwce_pkg::TICK_W-1:0] y,
                                input logic [pwce_pkg::TICK_W-1:0] sh,
                                input logic [pwce_pkg::TICK_W-1:0] lg);
    write_reg(pwce_pkg::REG_START_LOW, s);
    write_reg(pwce_pkg::REG_SYNC_HIGH, y);
    write_reg(pwce_pkg::REG_SHORT, sh);
    write_reg(pwce_pkg::REG_LONG, lg);
    wr_en <= 1'b0;
    settings++;
  endtask

  task automatic apply_timing(input int t);
    case (t)
      TIMING_RESET: program_timing(pwce_pkg::START_LOW_RST, pwce_pkg::SYNC_HIGH_RST,
                                   pwce_pkg::SHORT_RST, pwce_pkg::LONG_RST);
      TIMING_ZERO:  program_timing('0, '0, '0, '0);
      default:      program_timing('1, '1, '1, '1);
    endcase
  endtask

  // drop valid and hold until every result word is back
  task automatic drain_words();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (line_words.size() != 0);
  endtask

  task automatic pause_sender(input int g);
    if (g > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic offer(input logic k, input logic [pwce_pkg::DATA_BITS-1:0] c,
                       input bit typed, input line_word_t want);
    line_word_t got;
    cmd_if.valid        <= 1'b1;
    cmd_if.kind         <= k;
    cmd_if.command_code <= c;
    do @(posedge clk); while (!cmd_if.ready);
    if (k == pwce_pkg::KIND_START) begin
      starts++;
      if (sending_q) restarts++;
    end
    got = advance_line(k, c);
    line_words.push_back(typed ? want : got);
    words_sent++;
  endtask

  task automatic check_field(input string field, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, field, want, got);
      errors++;
    end
  endtask

  initial begin : result_sink
    int         run_left;
    int         hold_left;
    int         r;
    logic       nxt;
    line_word_t want;
    run_left  = 0;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        words_seen++;
        if (res_if.frame_done === 1'b1) frames_done++;
        if (line_words.size() == 0) begin
          $display("%0t: result word with nothing expected, got line %0b busy %0b done %0b",
                   $time, res_if.line_level, res_if.busy_res, res_if.frame_done);
          errors++;
        end else begin
          want = line_words.pop_front();
          check_field("line_level", want.line_level, res_if.line_level);
          check_field("busy_res", want.busy_res, res_if.busy_res);
          check_field("frame_done", want.frame_done, res_if.frame_done);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (squeeze_req) begin
        // long hold-off so the result register fills and the input stalls
        squeeze_req = 1'b0;
        hold_left   = HOLD_CYCLES - 1;
        holds++;
        nxt = 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        nxt = res_if.ready;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          nxt      = 1'b1;
          run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 150)
                                                 : $urandom_range(1, 30);
        end else begin
          nxt      = 1'b0;
          run_left = (r < 90) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        end
      end
      res_if.ready <= nxt;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no word moved for %0d cycles", $time, quiet);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int                             ph;
    int                             n;
    int                             r;
    bit                             calm;
    logic                           k;
    logic [pwce_pkg::DATA_BITS-1:0] c;

    t_start   = pwce_pkg::START_LOW_RST;
    t_sync    = pwce_pkg::SYNC_HIGH_RST;
    t_short   = pwce_pkg::SHORT_RST;
    t_long    = pwce_pkg::LONG_RST;
    cur_code  = '0;
    cur_seg   = '0;
    ticks_rem = '0;
    line_q    = 1'b1;
    sending_q = 1'b0;

    rst                 <= 1'b1;
    wr_en               <= 1'b0;
    wr_index            <= pwce_pkg::REG_START_LOW;
    wr_data             <= '0;
    cmd_if.valid        <= 1'b0;
    cmd_if.kind         <= pwce_pkg::KIND_TICK;
    cmd_if.command_code <= '0;

    // reset timing: idle tick, start, then ticks into a frame that a later restart cuts short
    add_row(TIMING_RESET, pwce_pkg::KIND_TICK, 4'h0, 1'b1, WORD_IDLE);
    add_row(TIMING_RESET, pwce_pkg::KIND_START, 4'hF, 1'b1, WORD_START);
    add_row(TIMING_RESET, pwce_pkg::KIND_TICK, 4'h0, 1'b0, WORD_IDLE);
    add_row(TIMING_RESET, pwce_pkg::KIND_TICK, 4'h0, 1'b0, WORD_IDLE);
    // zero lengths: running segment keeps its count, then each segment takes one tick
    add_row(TIMING_ZERO, pwce_pkg::KIND_TICK, 4'h0, 1'b0, WORD_IDLE);
    add_row(TIMING_ZERO, pwce_pkg::KIND_START, 4'h1, 1'b1, WORD_START);
    for (n = 0; n < 12; n++) add_row(TIMING_ZERO, pwce_pkg::KIND_TICK, 4'h0, 1'b0, WORD_IDLE);
    add_row(TIMING_ZERO, pwce_pkg::KIND_TICK, 4'h0, 1'b1, WORD_DONE);
    add_row(TIMING_ZERO, pwce_pkg::KIND_TICK, 4'hF, 1'b1, WORD_IDLE);
    // longest lengths, with a restart in the middle of the frame
    add_row(TIMING_MAX, pwce_pkg::KIND_START, 4'h0, 1'b1, WORD_START);
    add_row(TIMING_MAX, pwce_pkg::KIND_TICK, 4'h0, 1'b0, WORD_IDLE);
    add_row(TIMING_MAX, pwce_pkg::KIND_START, 4'h9, 1'b1, WORD_START);
    add_row(TIMING_MAX, pwce_pkg::KIND_TICK, 4'h6, 1'b0, WORD_IDLE);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    r = TIMING_RESET;
    foreach (script[i]) begin
      if (script[i].timing != r) begin
        drain_words();
        apply_timing(script[i].timing);
        r = script[i].timing;
      end
      offer(script[i].kind, script[i].code, script[i].typed, script[i].want);
      pause_sender(gap_len());
    end

    for (ph = 0; ph < PHASES; ph++) begin
      drain_words();
      if (ph == 0) program_timing(16'd1, 16'd1, 16'd1, 16'd1);
      else program_timing(pick_len(), pick_len(), pick_len(), pick_len());
      calm = (ph == SQUEEZE_PHASE) || ($urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (ph == SQUEEZE_PHASE && n == 5) squeeze_req = 1'b1;
        r = $urandom_range(0, 99);
        if (!sending_q) k = (r < 70) ? pwce_pkg::KIND_START : pwce_pkg::KIND_TICK;
        else k = (r < 3) ? pwce_pkg::KIND_START : pwce_pkg::KIND_TICK;
        c = pwce_pkg::DATA_BITS'($urandom_range(0, 15));
        offer(k, c, 1'b0, WORD_IDLE);
        pause_sender(calm ? 0 : gap_len());
      end
    end

    drain_words();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d command words (%0d starts, %0d restarts mid-frame)",
             words_sent, starts, restarts);
    $display("over %0d timing settings; checked %0d result words, %0d frames, %0d hold-offs.",
             settings, words_seen, frames_done, holds);
    if (errors == 0 && line_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
